// ===== src/wall_auxin_flux_unit_defines.svh =====
// assertion macros used by the port-level checker of the wall auxin flux unit
`ifndef WALL_AUXIN_FLUX_UNIT_DEFINES_SVH
`define WALL_AUXIN_FLUX_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define WAFU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wall auxin flux check failed");

// next-cycle implication, disabled while reset is asserted
`define WAFU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wall auxin flux check failed");

`endif

// ===== src/wafu_pkg.sv =====
// types and constants of the wall auxin flux unit
`timescale 1ns / 1ps

package wafu_pkg;

    localparam int DATA_W    = 31;
    localparam int OUT_W     = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int DEN_W     = DATA_W + 1;
    localparam int QUO_W     = DATA_W;
    localparam int IDX_W     = 3;
    localparam int S_TDATA_W = 160;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 2 * OUT_W;
    localparam logic [DATA_W-1:0] HALF_SAT_RESET = 31'd65536;

    typedef enum logic [IDX_W-1:0] {
        REG_DIFFUSION = 3'd0,
        REG_TRANSPORT = 3'd1,
        REG_HALF_SAT  = 3'd2,
        REG_TIP_RATE  = 3'd3,
        REG_SINK_RATE = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_TIP_FIRST,
        KIND_TIP_SECOND,
        KIND_SINK,
        KIND_INNER
    } kind_t;

endpackage

// ===== src/wafu_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module wafu_div
(
    input  logic                        clk,
    input  logic                        en,
    input  logic [wafu_pkg::PROD_W-1:0] num,
    input  logic [wafu_pkg::DEN_W-1:0]  den,
    output logic [wafu_pkg::QUO_W-1:0]  quo
);
    import wafu_pkg::*;

    logic [PROD_W-1:0] rem_reg [QUO_W-1];
    logic [DEN_W-1:0]  den_reg [QUO_W-1];
    logic [QUO_W-1:0]  quo_reg [QUO_W];
    logic [DEN_W-1:0]  den_fix;

    // zero divisor only occurs with a zero dividend: all-ones divisor yields zero
    assign den_fix = (den == '0) ? '1 : den;

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        localparam int SH = QUO_W - 1 - k;
        logic [PROD_W-1:0] rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [QUO_W-1:0]  quo_in;
        logic [PROD_W-1:0] trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den_fix;
            assign quo_in = '0;
        end
        else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign trial = PROD_W'(den_in) << SH;
        assign ge    = (rem_in >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[k] <= quo_in | (ge ? (QUO_W'(1) << SH) : '0);
            end
        end

        if (k < QUO_W - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? (rem_in - trial) : rem_in;
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule

// ===== src/wall_auxin_flux_unit.sv =====
// top level of the wall auxin flux unit
// pipeline: input register, three arithmetic stages, thirty-one divider stages and
//   the output register between input transfer and m_tvalid
// throughput: one wall per cycle; the whole pipe advances together and holds
//   while a result waits in the output register with m_tready low
// reset: clears all valid bits and restores the configuration registers to their defaults
`timescale 1ns / 1ps

module wall_auxin_flux_unit
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wafu_pkg::IDX_W-1:0]     cfg_index,
    input  logic [wafu_pkg::DATA_W-1:0]    cfg_data,
    // wall stream in
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // wall_length, auxin_first, auxin_second, pin_first_side, pin_second_side
    input  logic [wafu_pkg::S_TDATA_W-1:0] s_tdata,
    // first_on_boundary, second_on_boundary, is_source, is_sink
    input  logic [wafu_pkg::S_TUSER_W-1:0] s_tuser,
    // increment stream out
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // delta_first, delta_second
    output logic [wafu_pkg::M_TDATA_W-1:0] m_tdata,
    // saturated
    output logic                           m_tuser
);
    import wafu_pkg::*;

    localparam int MAG_W = PROD_W - FRAC_BITS;

    typedef struct packed {
        kind_t             kind;
        logic              neg;
        logic [MAG_W-1:0]  mag;
        logic [DATA_W-1:0] sl;
        logic              sat;
    } side_t;

    // (a*b) >> FRAC_BITS clamped to 31 bits; top bit flags the clamp
    function automatic logic [DATA_W:0] scale_clamp(input logic [PROD_W-1:0] p);
        logic over;
        begin
            over = (p >> (FRAC_BITS + DATA_W)) != '0;
            scale_clamp = {over, over ? {DATA_W{1'b1}} : p[FRAC_BITS +: DATA_W]};
        end
    endfunction

    // clamp to the 32-bit signed range; top bit flags the clamp
    function automatic logic [OUT_W:0] clamp_s32(input logic signed [63:0] v);
        logic hi;
        logic lo;
        begin
            hi = v > 64'sd2147483647;
            lo = v < -64'sd2147483648;
            if (hi)
                clamp_s32 = {1'b1, 32'h7fff_ffff};
            else if (lo)
                clamp_s32 = {1'b1, 32'h8000_0000};
            else
                clamp_s32 = {1'b0, v[OUT_W-1:0]};
        end
    endfunction

    // configuration registers
    logic [DATA_W-1:0] diff_coeff_reg;
    logic [DATA_W-1:0] trans_rate_reg;
    logic [DATA_W-1:0] half_sat_reg;
    logic [DATA_W-1:0] tip_rate_reg;
    logic [DATA_W-1:0] sink_rate_reg;

    // pipe control
    logic adv;

    // stage 1: captured input
    logic              i_valid_reg;
    logic [3:0]        i_flags_reg;
    logic [DATA_W-1:0] i_len_reg;
    logic [DATA_W-1:0] i_a1_reg;
    logic [DATA_W-1:0] i_a2_reg;
    logic [DATA_W-1:0] i_p1_reg;
    logic [DATA_W-1:0] i_p2_reg;
    kind_t             i_kind;

    // stage 2: raw products
    logic              p_valid_reg;
    kind_t             p_kind_reg;
    logic [PROD_W-1:0] p_sl_reg;
    logic [PROD_W-1:0] p_g_reg;
    logic [PROD_W-1:0] p_r1_reg;
    logic [PROD_W-1:0] p_r2_reg;
    logic [DATA_W-1:0] p_a1_reg;
    logic [DATA_W-1:0] p_a2_reg;

    // stage 3: scaled and clamped terms
    logic              c_valid_reg;
    kind_t             c_kind_reg;
    logic [DATA_W-1:0] c_sl_reg;
    logic [DATA_W-1:0] c_g_reg;
    logic [DATA_W-1:0] c_r1_reg;
    logic [DATA_W-1:0] c_r2_reg;
    logic              c_sat_reg;
    logic              c_neg_reg;
    logic [DATA_W-1:0] c_diff_reg;
    logic [DATA_W-1:0] c_a1_reg;
    logic [DATA_W-1:0] c_a2_reg;
    logic [DATA_W:0]   sc_sl;
    logic [DATA_W:0]   sc_g;
    logic [DATA_W:0]   sc_r1;
    logic [DATA_W:0]   sc_r2;
    logic              c_sat_next;

    // stage 4: diffusion product, transport numerators and divisors
    logic              m_valid_reg;
    kind_t             m_kind_reg;
    logic              m_neg_reg;
    logic [DATA_W-1:0] m_sl_reg;
    logic              m_sat_reg;
    logic [PROD_W-1:0] m_phi_reg;
    logic [PROD_W-1:0] m_num1_reg;
    logic [PROD_W-1:0] m_num2_reg;
    logic [DEN_W-1:0]  m_den1_reg;
    logic [DEN_W-1:0]  m_den2_reg;
    logic [DATA_W-1:0] rate2;

    // side data traveling beside the dividers
    logic              d_valid_reg [QUO_W];
    side_t             d_side_reg  [QUO_W];
    side_t             d_side_in;
    logic [QUO_W-1:0]  t12;
    logic [QUO_W-1:0]  t21;

    // result assembly and output register
    side_t             f_side;
    logic signed [63:0] phi;
    logic signed [63:0] sum1;
    logic signed [63:0] sum2;
    logic [OUT_W:0]    cl1;
    logic [OUT_W:0]    cl2;
    logic [OUT_W-1:0]  d1_next;
    logic [OUT_W-1:0]  d2_next;
    logic              sat_next;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_d1_reg;
    logic [OUT_W-1:0]  out_d2_reg;
    logic              out_sat_reg;

    // the pipe moves whenever the output register is empty or being drained
    assign adv       = !out_valid_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_coeff_reg <= '0;
            trans_rate_reg <= '0;
            half_sat_reg   <= HALF_SAT_RESET;
            tip_rate_reg   <= '0;
            sink_rate_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DIFFUSION: diff_coeff_reg <= cfg_data;
                REG_TRANSPORT: trans_rate_reg <= cfg_data;
                REG_HALF_SAT:  half_sat_reg   <= cfg_data;
                REG_TIP_RATE:  tip_rate_reg   <= cfg_data;
                REG_SINK_RATE: sink_rate_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits of every stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_valid_reg   <= 1'b0;
            p_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < QUO_W; k++)
                d_valid_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            i_valid_reg    <= s_tvalid;
            p_valid_reg    <= i_valid_reg;
            c_valid_reg    <= p_valid_reg;
            m_valid_reg    <= c_valid_reg;
            d_valid_reg[0] <= m_valid_reg;
            for (int k = 1; k < QUO_W; k++)
                d_valid_reg[k] <= d_valid_reg[k-1];
            out_valid_reg  <= d_valid_reg[QUO_W-1];
        end
    end

    // stage 1: unpack the transfer
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            i_flags_reg <= s_tuser;
            i_len_reg   <= s_tdata[0*DATA_W +: DATA_W];
            i_a1_reg    <= s_tdata[1*DATA_W +: DATA_W];
            i_a2_reg    <= s_tdata[2*DATA_W +: DATA_W];
            i_p1_reg    <= s_tdata[3*DATA_W +: DATA_W];
            i_p2_reg    <= s_tdata[4*DATA_W +: DATA_W];
        end
    end

    // wall class: second boundary first, source wins over sink
    always_comb
    begin
        if (i_flags_reg[1])
            i_kind = i_flags_reg[2] ? KIND_TIP_FIRST : KIND_NONE;
        else if (i_flags_reg[0])
            i_kind = i_flags_reg[2] ? KIND_TIP_SECOND
                   : (i_flags_reg[3] ? KIND_SINK : KIND_NONE);
        else
            i_kind = KIND_INNER;
    end

    // stage 2: four independent 31x31 products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_kind_reg <= i_kind;
            p_sl_reg   <= tip_rate_reg * i_len_reg;
            p_g_reg    <= i_len_reg * diff_coeff_reg;
            p_r1_reg   <= trans_rate_reg * i_p1_reg;
            p_r2_reg   <= trans_rate_reg * i_p2_reg;
            p_a1_reg   <= i_a1_reg;
            p_a2_reg   <= i_a2_reg;
        end
    end

    // stage 3: scale, clamp and collect clamp flags that count for this class
    assign sc_sl = scale_clamp(p_sl_reg);
    assign sc_g  = scale_clamp(p_g_reg);
    assign sc_r1 = scale_clamp(p_r1_reg);
    assign sc_r2 = scale_clamp(p_r2_reg);

    always_comb
    begin
        case (p_kind_reg) inside
            KIND_TIP_FIRST, KIND_TIP_SECOND: c_sat_next = sc_sl[DATA_W];
            KIND_INNER: c_sat_next = sc_g[DATA_W] | sc_r1[DATA_W] | sc_r2[DATA_W];
            default:    c_sat_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_kind_reg <= p_kind_reg;
            c_sl_reg   <= sc_sl[DATA_W-1:0];
            c_g_reg    <= sc_g[DATA_W-1:0];
            c_r1_reg   <= sc_r1[DATA_W-1:0];
            c_r2_reg   <= sc_r2[DATA_W-1:0];
            c_sat_reg  <= c_sat_next;
            c_neg_reg  <= p_a1_reg > p_a2_reg;
            c_diff_reg <= (p_a1_reg > p_a2_reg) ? (p_a1_reg - p_a2_reg)
                                                : (p_a2_reg - p_a1_reg);
            c_a1_reg   <= p_a1_reg;
            c_a2_reg   <= p_a2_reg;
        end
    end

    // stage 4: sink efflux borrows the second transport lane
    assign rate2 = (c_kind_reg == KIND_SINK) ? sink_rate_reg : c_r2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_kind_reg <= c_kind_reg;
            m_neg_reg  <= c_neg_reg;
            m_sl_reg   <= c_sl_reg;
            m_sat_reg  <= c_sat_reg;
            m_phi_reg  <= c_g_reg * c_diff_reg;
            m_num1_reg <= c_r1_reg * c_a1_reg;
            m_num2_reg <= rate2 * c_a2_reg;
            m_den1_reg <= DEN_W'(half_sat_reg) + DEN_W'(c_a1_reg);
            m_den2_reg <= DEN_W'(half_sat_reg) + DEN_W'(c_a2_reg);
        end
    end

    // Michaelis-Menten quotients, thirty-one stages each
    wafu_div u_div_first
    (
        .clk (clk),
        .en  (adv),
        .num (m_num1_reg),
        .den (m_den1_reg),
        .quo (t12)
    );

    wafu_div u_div_second
    (
        .clk (clk),
        .en  (adv),
        .num (m_num2_reg),
        .den (m_den2_reg),
        .quo (t21)
    );

    // diffusion magnitude and class ride along with the dividers
    always_comb
    begin
        d_side_in.kind = m_kind_reg;
        d_side_in.neg  = m_neg_reg;
        d_side_in.mag  = m_phi_reg[PROD_W-1:FRAC_BITS];
        d_side_in.sl   = m_sl_reg;
        d_side_in.sat  = m_sat_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_side_reg[0] <= d_side_in;
            for (int k = 1; k < QUO_W; k++)
                d_side_reg[k] <= d_side_reg[k-1];
        end
    end

    // final sums and clamps
    assign f_side = d_side_reg[QUO_W-1];
    assign phi    = f_side.neg ? -$signed(64'(f_side.mag)) : $signed(64'(f_side.mag));
    assign sum1   = phi + $signed(64'(t21)) - $signed(64'(t12));
    assign sum2   = -phi + $signed(64'(t12)) - $signed(64'(t21));
    assign cl1    = clamp_s32(sum1);
    assign cl2    = clamp_s32(sum2);

    always_comb
    begin
        d1_next  = '0;
        d2_next  = '0;
        sat_next = f_side.sat;
        case (f_side.kind)
            KIND_TIP_FIRST:  d1_next = OUT_W'(f_side.sl);
            KIND_TIP_SECOND: d2_next = OUT_W'(f_side.sl);
            KIND_SINK:       d2_next = -OUT_W'(t21);
            KIND_INNER:
            begin
                d1_next  = cl1[OUT_W-1:0];
                d2_next  = cl2[OUT_W-1:0];
                sat_next = f_side.sat | cl1[OUT_W] | cl2[OUT_W];
            end
            default: ;
        endcase
    end

    // output register parts the pipe from the downstream side
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_d1_reg  <= d1_next;
            out_d2_reg  <= d2_next;
            out_sat_reg <= sat_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_d2_reg, out_d1_reg};
    assign m_tuser  = out_sat_reg;

endmodule

// ===== src/wafu_checker.sv =====
// port-level checker for the wall auxin flux unit, with its bind
`timescale 1ns / 1ps
`include "wall_auxin_flux_unit_defines.svh"

module wafu_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);
    import wafu_pkg::*;

    logic [OUT_W-1:0] chk_sum;

    assign chk_sum = m_tdata[31:0] + m_tdata[63:32];

    // a held result stalls the whole pipe, input side included
    `WAFU_ASSERT_NOW(a_stall_blocks_input, clk, rst_n, m_tvalid && !m_tready, !s_tready)

    // unclipped results are one-sided or exactly opposite
    `WAFU_ASSERT_NOW(a_flux_balance, clk, rst_n, m_tvalid && !m_tuser,
        m_tdata[31:0] == '0 || m_tdata[63:32] == '0 || chk_sum == '0)

    // a stalled result holds
    `WAFU_ASSERT_NEXT(a_hold_result, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind wall_auxin_flux_unit wafu_checker u_wafu_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== dv/wall_auxin_flux_checker.sv =====
// checker that predicts and compares wall auxin flux results
`timescale 1ns / 1ps

module wall_auxin_flux_checker
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [wafu_pkg::IDX_W-1:0]       cfg_index,
    input  logic [wafu_pkg::DATA_W-1:0]      cfg_data,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [wafu_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [wafu_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [wafu_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             m_tuser,
    output int                               fail_count,
    output int                               pending_count
);
    import wafu_pkg::*;

    localparam bit [63:0] MAX31 = 64'h7FFF_FFFF;

    typedef struct packed {
        logic [31:0] d_first;
        logic [31:0] d_second;
        logic        sat;
    } increment_t;

    bit [63:0] diff_coeff, trans_rate, half_sat, tip_rate, sink_rate;
    increment_t expected_incr[$];

    function automatic bit [63:0] fix_mul(input bit [63:0] a, input bit [63:0] b,
                                          inout bit sat);
        bit [63:0] p;
        p = (a * b) >> FRAC_BITS;
        if (p > MAX31)
        begin
            sat = 1'b1;
            p   = MAX31;
        end
        return p;
    endfunction

    function automatic bit [63:0] michaelis(input bit [63:0] rate, input bit [63:0] x);
        bit [63:0] den;
        den = half_sat + x;
        if (den == '0)
            return '0;
        return (rate * x) / den;
    endfunction

    function automatic longint clip32(input longint v, inout bit sat);
        if (v > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic increment_t wall_flux(input logic [S_TUSER_W-1:0] flags,
                                             input logic [S_TDATA_W-1:0] data);
        bit [63:0] len, a1, a2, p1, p2, g, dif, mag, r1, r2;
        longint phi, t12, t21, d1, d2;
        bit sat, neg;
        increment_t r;
        len = 64'(data[30:0]);
        a1  = 64'(data[61:31]);
        a2  = 64'(data[92:62]);
        p1  = 64'(data[123:93]);
        p2  = 64'(data[154:124]);
        sat = 1'b0;
        d1  = 0;
        d2  = 0;
        if (flags[1])
        begin
            if (flags[2])
                d1 = longint'(fix_mul(tip_rate, len, sat));
        end
        else if (flags[0])
        begin
            if (flags[2])
                d2 = longint'(fix_mul(tip_rate, len, sat));
            else if (flags[3])
                d2 = -longint'(michaelis(sink_rate, a2));
        end
        else
        begin
            g   = fix_mul(len, diff_coeff, sat);
            neg = a1 > a2;
            dif = neg ? a1 - a2 : a2 - a1;
            mag = (g * dif) >> FRAC_BITS;
            phi = neg ? -longint'(mag) : longint'(mag);
            r1  = fix_mul(trans_rate, p1, sat);
            r2  = fix_mul(trans_rate, p2, sat);
            t12 = longint'(michaelis(r1, a1));
            t21 = longint'(michaelis(r2, a2));
            d1  = clip32(phi + t21 - t12, sat);
            d2  = clip32(-phi + t12 - t21, sat);
        end
        r.d_first  = d1[31:0];
        r.d_second = d2[31:0];
        r.sat      = sat;
        return r;
    endfunction

    assign pending_count = expected_incr.size();

    always @(posedge clk or negedge rst_n)
    begin
        increment_t exp_r;
        if (!rst_n)
        begin
            diff_coeff = '0;
            trans_rate = '0;
            half_sat   = 64'(HALF_SAT_RESET);
            tip_rate   = '0;
            sink_rate  = '0;
            expected_incr.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DIFFUSION: diff_coeff = 64'(cfg_data);
                    REG_TRANSPORT: trans_rate = 64'(cfg_data);
                    REG_HALF_SAT:  half_sat   = 64'(cfg_data);
                    REG_TIP_RATE:  tip_rate   = 64'(cfg_data);
                    REG_SINK_RATE: sink_rate  = 64'(cfg_data);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_incr.push_back(wall_flux(s_tuser, s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (expected_incr.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result d1=%h d2=%h sat=%b",
                                 m_tdata[31:0], m_tdata[63:32], m_tuser);
                end
                else
                begin
                    exp_r = expected_incr.pop_front();
                    if (exp_r.d_first !== m_tdata[31:0] || exp_r.d_second !== m_tdata[63:32]
                        || exp_r.sat !== m_tuser)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch exp d1=%h d2=%h sat=%b got d1=%h d2=%h sat=%b",
                                     exp_r.d_first, exp_r.d_second, exp_r.sat,
                                     m_tdata[31:0], m_tdata[63:32], m_tuser);
                    end
                end
            end
        end
    end

endmodule

// ===== dv/tb_wall_auxin_flux_unit.sv =====
// stimulus and verdict for the wall auxin flux unit
`timescale 1ns / 1ps

module tb_wall_auxin_flux_unit;
    import wafu_pkg::*;

    localparam int  LIMIT  = 400000;   // cycles, generous over the slowest run
    localparam int  DRAIN  = 50;       // margin past the depth of the pipe
    localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;
    localparam logic [30:0] ONE   = 31'd65536;
    localparam logic [30:0] ZERO  = 31'd0;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    cfg_index_t           cfg_index;
    logic [DATA_W-1:0]    cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    // wall_length, auxin_first, auxin_second, pin_first_side, pin_second_side
    logic [S_TDATA_W-1:0] s_tdata;
    // first_on_boundary, second_on_boundary, is_source, is_sink
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // delta_first, delta_second
    logic [M_TDATA_W-1:0] m_tdata;
    // saturated
    logic                 m_tuser;

    int fail_count;
    int pending_count;
    int cycles;
    int burst_left;

    wall_auxin_flux_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    wall_auxin_flux_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit: a hung pipe ends here
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("tb_wall_auxin_flux_unit failed");
                $finish;
            end
        end
    end

    // receiver: random stall pattern, stretches of full speed, one long hold-off
    initial
    begin
        int mode;
        int stretch;
        m_tready = 1'b0;
        @(posedge rst_n);
        repeat (400)
        begin
            m_tready <= ($urandom_range(0, 3) != 0);
            @(posedge clk);
        end
        // long hold-off while the sender keeps offering: the pipe fills and stalls
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        forever
        begin
            mode    = $urandom_range(0, 2);
            stretch = $urandom_range(10, 80);
            repeat (stretch)
            begin
                @(posedge clk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    default: m_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // field values biased toward the extremes and toward small fixed-point numbers
    function automatic logic [30:0] pick31();
        case ($urandom_range(0, 5))
            0: return 31'd0;
            1: return MAX31;
            2: return 31'($urandom_range(0, 32'h0004_0000));
            3: return 31'($urandom_range(0, 32'h0000_0100));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic logic [S_TUSER_W-1:0] pick_flags();
        logic [S_TUSER_W-1:0] f;
        f = 4'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: f[1:0] = 2'b00;   // inner wall
            5, 6: f[1:0] = 2'b10;            // second cell on boundary
            7, 8: f[1:0] = 2'b01;            // first cell on boundary
            default: ;
        endcase
        return f;
    endfunction

    // one transfer on the wall stream; valid stays up within a burst
    task automatic send_wall(input logic [S_TUSER_W-1:0] flags, input logic [30:0] len,
                             input logic [30:0] a1, input logic [30:0] a2,
                             input logic [30:0] p1, input logic [30:0] p2);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= flags;
        s_tdata  <= {5'd0, p2, p1, a2, a1, len};
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [30:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic set_rates(input logic [30:0] d, input logic [30:0] t, input logic [30:0] k,
                             input logic [30:0] s, input logic [30:0] e);
        write_reg(REG_DIFFUSION, d);
        write_reg(REG_TRANSPORT, t);
        write_reg(REG_HALF_SAT, k);
        write_reg(REG_TIP_RATE, s);
        write_reg(REG_SINK_RATE, e);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // stop offering, let every expected transfer come back, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic random_walls(input int n);
        repeat (n)
            send_wall(pick_flags(), pick31(), pick31(), pick31(), pick31(), pick31());
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_DIFFUSION;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        burst_left = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, under reset defaults: inner, tip on either side and sink walls
        send_wall(4'b0000, ONE, ONE, ZERO, ONE, ONE);
        send_wall(4'b0110, MAX31, ZERO, ZERO, ZERO, ZERO);
        send_wall(4'b0101, MAX31, ZERO, ZERO, ZERO, ZERO);
        send_wall(4'b1001, ZERO, ZERO, MAX31, ZERO, ZERO);
        drain();

        // directed with large rates: clipped products, source beats sink, both boundaries
        set_rates(MAX31, MAX31, ONE, MAX31, MAX31);
        send_wall(4'b0110, MAX31, ZERO, ZERO, ZERO, ZERO);
        send_wall(4'b0100, ONE, ZERO, ZERO, ZERO, ZERO);
        send_wall(4'b1101, ONE, ZERO, ONE, ZERO, ZERO);
        send_wall(4'b1001, ONE, ZERO, MAX31, ZERO, ZERO);
        send_wall(4'b1001, ONE, ZERO, ZERO, ZERO, ZERO);
        send_wall(4'b1111, MAX31, MAX31, MAX31, MAX31, MAX31);
        send_wall(4'b0000, MAX31, ZERO, MAX31, ZERO, ZERO);
        send_wall(4'b0000, MAX31, MAX31, ZERO, ZERO, ZERO);
        send_wall(4'b0000, MAX31, MAX31, MAX31, MAX31, MAX31);
        send_wall(4'b0000, ZERO, MAX31, ZERO, MAX31, ZERO);
        send_wall(4'b0000, ZERO, ZERO, MAX31, ZERO, MAX31);
        send_wall(4'b1000, ONE, ONE, ONE, ZERO, ZERO);
        drain();

        // zero Michaelis constant: a zero level gives a zero divisor
        set_rates(ONE, ONE, ZERO, ONE, ONE);
        send_wall(4'b0000, ONE, ZERO, ZERO, MAX31, MAX31);
        send_wall(4'b1001, ONE, ZERO, ZERO, ZERO, ZERO);
        send_wall(4'b0000, ONE, ZERO, ONE, ONE, ONE);
        random_walls(150);
        drain();

        set_rates(31'h0001_8000, 31'h0000_8000, ONE, 31'h0002_0000, 31'h0003_0000);
        random_walls(350);
        drain();

        set_rates(MAX31, MAX31, MAX31, MAX31, MAX31);
        random_walls(200);
        drain();

        set_rates(ZERO, ZERO, ZERO, ZERO, ZERO);
        random_walls(100);
        drain();

        set_rates(31'($urandom), 31'($urandom), 31'($urandom_range(1, 32'h0010_0000)),
                  31'($urandom_range(0, 32'h0010_0000)), 31'($urandom));
        random_walls(200);
        drain();

        set_rates(31'($urandom_range(0, 32'h0004_0000)), 31'($urandom_range(0, 32'h0004_0000)),
                  31'($urandom_range(0, 32'h0004_0000)), 31'($urandom_range(0, 32'h0004_0000)),
                  31'($urandom_range(0, 32'h0004_0000)));
        random_walls(200);
        drain();

        if (fail_count == 0)
            $display("tb_wall_auxin_flux_unit passed");
        else
            $display("tb_wall_auxin_flux_unit failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/wafu_pkg.sv
src/wafu_div.sv
src/wall_auxin_flux_unit.sv
src/wafu_checker.sv
dv/wall_auxin_flux_checker.sv
dv/tb_wall_auxin_flux_unit.sv
